[design/ah256_pkg.sv]
package ah256_pkg;

	localparam int ROUNDS = 12;
	localparam int RND_W = 4;
	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
	localparam int DIGEST_WORDS = 4;
	localparam logic [1:0] LAST_INDEX = 2'(DIGEST_WORDS - 1);
	localparam int RATE_BYTES = 8;

	// queue depth must be a power of two: pointers wrap by overflow
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [4:0][63:0] sponge_t;

	// unpermuted Ascon-Hash256 initial value, word 0 in the low slot
	localparam sponge_t IV_RAW = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0000080100cc0002};

	typedef struct packed {
		logic [63:0] message_word;
		logic [3:0]  byte_count;
		logic        end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
		logic        error;
	} dig_item_t;

	typedef enum logic [1:0] {
		CMD_ABSORB,
		CMD_FINAL,
		CMD_FINAL_FULL,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [63:0] word;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		NX_IDLE,
		NX_PAD,
		NX_SQUEEZE
	} next_act_t;

	function automatic logic [7:0] round_const(input logic [RND_W-1:0] rnd);
		return {4'hf - rnd, rnd};
	endfunction

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic sponge_t ascon_round(input sponge_t s, input logic [7:0] rc);
		logic [63:0] x0, x1, x2, x3, x4;
		logic [63:0] t0, t1, t2, t3, t4;
		sponge_t r;
		x0 = s[0];
		x1 = s[1];
		x2 = s[2] ^ {56'h0, rc};
		x3 = s[3];
		x4 = s[4];
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;
		r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
		r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
		r[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
		r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
		r[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
		return r;
	endfunction

endpackage

[design/ah256_front.sv]
module ah256_front import ah256_pkg::*; (
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_item_t msg,
	input  logic      q_full,
	output logic      push,
	output cmd_t      push_cmd
);

	logic [3:0] cnt;
	logic [63:0] padded;

	assign cnt = (msg.byte_count > 4'(RATE_BYTES)) ? 4'(RATE_BYTES) : msg.byte_count;

	// keep bytes below the count, put the pad byte right above them
	always_comb begin
		for (int i = 0; i < RATE_BYTES; i++) begin
			if (4'(i) < cnt) begin
				padded[8*i +: 8] = msg.message_word[8*i +: 8];
			end else if (4'(i) == cnt) begin
				padded[8*i +: 8] = 8'h01;
			end else begin
				padded[8*i +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		push_cmd.word = msg.message_word;
		if (!msg.end_of_message) begin
			push_cmd.kind = (cnt == 4'(RATE_BYTES)) ? CMD_ABSORB : CMD_ERROR;
		end else if (cnt == 4'(RATE_BYTES)) begin
			push_cmd.kind = CMD_FINAL_FULL;
		end else begin
			push_cmd.kind = CMD_FINAL;
			push_cmd.word = padded;
		end
	end

	assign msg_ready = !q_full;
	assign push = msg_valid && !q_full;

endmodule

[design/ah256_queue.sv]
module ah256_queue import ah256_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic nonempty
);

	cmd_t entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");

endmodule

[design/ah256_back.sv]
module ah256_back import ah256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_nonempty,
	input  cmd_t      q_cmd,
	output logic      pop,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_item_t dig
);

	back_state_t st_q, st_d;
	sponge_t state_q;
	logic [RND_W-1:0] rnd_q, rnd_d, rc_idx;
	next_act_t nx_q, nx_d;
	logic pad_q, pad_d;
	logic [1:0] k_q, k_d;
	logic out_valid_q;
	dig_item_t out_q, out_d;
	logic out_wr, emit_digest, round_en, slot_free;
	sponge_t base, rin, rout;
	logic [63:0] x0_mix;

	assign slot_free = !out_valid_q || dig_ready;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (q_nonempty && q_cmd.kind != CMD_ERROR) begin
					st_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (rnd_q == LAST_ROUND) begin
					case (nx_q)
						NX_IDLE: st_d = BK_IDLE;
						NX_PAD: st_d = BK_RUN;
						NX_SQUEEZE: st_d = BK_EMIT;
						default: st_d = BK_IDLE;
					endcase
				end
			end
			BK_EMIT: begin
				if (slot_free) begin
					st_d = BK_RUN;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		round_en = 1'b0;
		base = state_q;
		x0_mix = '0;
		rc_idx = rnd_q;
		rnd_d = rnd_q;
		nx_d = nx_q;
		pad_d = pad_q;
		k_d = k_q;
		out_wr = 1'b0;
		emit_digest = 1'b0;
		out_d = out_q;
		case (st_q)
			BK_IDLE: begin
				pop = q_nonempty && (q_cmd.kind != CMD_ERROR || slot_free);
				if (pop && q_cmd.kind == CMD_ERROR) begin
					out_wr = 1'b1;
					out_d = '{digest_word: 64'h0, word_index: 2'd0, last_word: 1'b1,
						error: 1'b1};
				end else if (pop) begin
					// fold the absorb into round zero
					round_en = 1'b1;
					x0_mix = q_cmd.word;
					rc_idx = '0;
					rnd_d = RND_W'(1);
					pad_d = 1'b0;
					case (q_cmd.kind)
						CMD_FINAL: nx_d = NX_SQUEEZE;
						CMD_FINAL_FULL: nx_d = NX_PAD;
						default: nx_d = NX_IDLE;
					endcase
				end
			end
			BK_RUN: begin
				round_en = 1'b1;
				x0_mix = {63'h0, pad_q && rnd_q == '0};
				if (rnd_q == LAST_ROUND) begin
					rnd_d = '0;
					pad_d = (nx_q == NX_PAD);
					if (nx_q == NX_PAD) begin
						nx_d = NX_SQUEEZE;
					end
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			BK_EMIT: begin
				if (slot_free) begin
					emit_digest = 1'b1;
					out_wr = 1'b1;
					out_d = '{digest_word: state_q[0], word_index: k_q,
						last_word: k_q == LAST_INDEX, error: 1'b0};
					round_en = 1'b1;
					rc_idx = '0;
					rnd_d = RND_W'(1);
					pad_d = 1'b0;
					if (k_q == LAST_INDEX) begin
						// restart from the initial value for the next message
						base = IV_RAW;
						nx_d = NX_IDLE;
						k_d = '0;
					end else begin
						nx_d = NX_SQUEEZE;
						k_d = k_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rin = base;
		rin[0] = base[0] ^ x0_mix;
	end

	assign rout = ascon_round(rin, round_const(rc_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_RUN;
			state_q <= IV_RAW;
			rnd_q <= '0;
			nx_q <= NX_IDLE;
			pad_q <= 1'b0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			rnd_q <= rnd_d;
			nx_q <= nx_d;
			pad_q <= pad_d;
			k_q <= k_d;
			if (round_en) begin
				state_q <= rout;
			end
			if (out_wr) begin
				out_valid_q <= 1'b1;
			end else if (dig_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_q <= out_d;
		end
	end

	assign dig_valid = out_valid_q;
	assign dig = out_q;

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_RUN |-> rnd_q <= LAST_ROUND) else $error("round counter out of range");
	a_absorb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == BK_RUN && rnd_q == LAST_ROUND && nx_q == NX_IDLE) |=> st_q == BK_IDLE)
		else $error("permutation end missed");
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.error) |-> (out_q.last_word && out_q.digest_word == 64'h0
		&& out_q.word_index == 2'd0)) else $error("malformed error item");
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_digest && k_q != LAST_INDEX) |=> k_q == $past(k_q) + 2'd1)
		else $error("digest index skipped");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dig_ready) |-> !out_wr) else $error("result overwritten");

endmodule

[design/ascon_hash256_engine.sv]
// Ascon-Hash256 engine. Message words enter on msg (byte i at bits 8i..8i+7,
// byte_count valid bytes, end_of_message on the final item); the 256-bit digest
// leaves on dig as four words with word_index 0..3, last_word on the fourth. A
// non-final item with fewer than eight bytes is dropped and answered by one item
// with error and last_word set. One shared Ascon round unit runs one round per
// cycle. A full non-final word takes one permutation; a final word takes one to
// absorb and one for each of the four squeezed words, the last of which also
// rebuilds the initial value, and one more for the extra padding block when the
// final word is full. An error item is answered without running a round. After
// reset the raw initial value is permuted before the first word is absorbed. A
// four-entry command queue lets input be taken while the round unit is busy, and
// a result register lets the round unit go on while a result waits to be taken.
module ascon_hash256_engine import ah256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_item_t dig
);

	logic q_full, q_nonempty, push, pop;
	cmd_t push_cmd, pop_cmd;

	ah256_front u_front (
		.msg_valid(msg_valid),
		.msg_ready(msg_ready),
		.msg(msg),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	ah256_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.nonempty(q_nonempty)
	);

	ah256_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nonempty(q_nonempty),
		.q_cmd(pop_cmd),
		.pop(pop),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig(dig)
	);

endmodule

[tb/ascon_hash256_checker.sv]
`timescale 1ns / 100ps

module ascon_hash256_checker import ah256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	input  logic      msg_ready,
	input  msg_item_t msg,
	input  logic      dig_valid,
	input  logic      dig_ready,
	input  dig_item_t dig,
	output int        owed_words,
	output int        fail_count
);

	localparam logic [63:0] HASH_IV_WORD = 64'h0000080100cc0002;
	localparam logic [63:0] PAD_BYTE = 64'h01;

	logic [4:0][63:0] sponge;
	dig_item_t pending_digest[$];
	int mismatches;

	function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [4:0][63:0] sponge_permute(input logic [4:0][63:0] s);
		logic [63:0] a0, a1, a2, a3, a4;
		logic [63:0] n0, n1, n2, n3, n4;
		a0 = s[0];
		a1 = s[1];
		a2 = s[2];
		a3 = s[3];
		a4 = s[4];
		for (int r = 0; r < 12; r++) begin
			// round constants step down from 0xf0 by 0x0f
			a2 = a2 ^ 64'(8'hf0 - 8'(r * 15));
			a0 = a0 ^ a4;
			a4 = a4 ^ a3;
			a2 = a2 ^ a1;
			n0 = ~a0 & a1;
			n1 = ~a1 & a2;
			n2 = ~a2 & a3;
			n3 = ~a3 & a4;
			n4 = ~a4 & a0;
			a0 = a0 ^ n1;
			a1 = a1 ^ n2;
			a2 = a2 ^ n3;
			a3 = a3 ^ n4;
			a4 = a4 ^ n0;
			a1 = a1 ^ a0;
			a0 = a0 ^ a4;
			a3 = a3 ^ a2;
			a2 = ~a2;
			a0 = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
			a1 = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
			a2 = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
			a3 = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
			a4 = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
		end
		return {a4, a3, a2, a1, a0};
	endfunction

	function automatic logic [4:0][63:0] initial_sponge();
		logic [4:0][63:0] s;
		s = '0;
		s[0] = HASH_IV_WORD;
		return sponge_permute(s);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic hash_absorb(input msg_item_t item);
		int cnt;
		logic [63:0] mask;
		cnt = (item.byte_count > RATE_BYTES) ? RATE_BYTES : int'(item.byte_count);
		if (!item.end_of_message) begin
			if (cnt < RATE_BYTES) begin
				// short word inside a message: drop it, answer with one error item
				pending_digest.push_back('{digest_word: '0, word_index: '0,
					last_word: 1'b1, error: 1'b1});
			end else begin
				sponge[0] = sponge[0] ^ item.message_word;
				sponge = sponge_permute(sponge);
			end
			return;
		end
		if (cnt == RATE_BYTES) begin
			sponge[0] = sponge[0] ^ item.message_word;
			sponge = sponge_permute(sponge);
			sponge[0] = sponge[0] ^ PAD_BYTE;
		end else begin
			mask = (cnt == 0) ? '0 : ({64{1'b1}} >> (64 - 8 * cnt));
			sponge[0] = sponge[0] ^ (item.message_word & mask) ^ (PAD_BYTE << (8 * cnt));
		end
		sponge = sponge_permute(sponge);
		for (int k = 0; k < DIGEST_WORDS; k++) begin
			pending_digest.push_back('{digest_word: sponge[0], word_index: 2'(k),
				last_word: (k == DIGEST_WORDS - 1), error: 1'b0});
			sponge = sponge_permute(sponge);
		end
		sponge = initial_sponge();
	endtask

	task automatic check_digest(input dig_item_t got);
		dig_item_t want;
		if (pending_digest.size() == 0) begin
			report_mismatch("digest item with nothing pending", got.digest_word, '0);
			return;
		end
		want = pending_digest.pop_front();
		if (got.digest_word !== want.digest_word)
			report_mismatch("digest_word", got.digest_word, want.digest_word);
		if (got.word_index !== want.word_index)
			report_mismatch("word_index", 64'(got.word_index), 64'(want.word_index));
		if (got.last_word !== want.last_word)
			report_mismatch("last_word", 64'(got.last_word), 64'(want.last_word));
		if (got.error !== want.error)
			report_mismatch("error", 64'(got.error), 64'(want.error));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sponge = initial_sponge();
			pending_digest.delete();
			mismatches = 0;
		end else begin
			if (msg_valid && msg_ready)
				hash_absorb(msg);
			if (dig_valid && dig_ready)
				check_digest(dig);
		end
		// publish after the edge so readers at this edge see the old values
		owed_words <= pending_digest.size();
		fail_count <= mismatches;
	end

endmodule

[tb/ascon_hash256_engine_tb.sv]
`timescale 1ns / 100ps

module ascon_hash256_engine_tb import ah256_pkg::*;;

	localparam int RANDOM_ITEMS = 192;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AT_WORD = 40;
	localparam int TAIL_CYCLES = 120;

	logic      clk;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_ready;
	msg_item_t msg;
	logic      dig_valid;
	logic      dig_ready;
	dig_item_t dig;
	int        owed_words;
	int        fail_count;
	int        send_burst = 0;
	int        take_burst = 0;

	ascon_hash256_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	ascon_hash256_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_ready  (dig_ready),
		.dig        (dig),
		.owed_words (owed_words),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly random waits, with occasional stretches of back-to-back items
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0)
			burst = $urandom_range(6, 24);
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic send_item(input logic [63:0] word, input int count, input bit last);
		int gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg <= '{message_word: word, byte_count: 4'(count), end_of_message: last};
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_ready !== 1'b1) @(posedge clk);
	endtask

	initial begin
		int gap;
		int words_taken;
		bit held;
		words_taken = 0;
		held = 1'b0;
		dig_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (words_taken == HOLD_AT_WORD && !held) begin
				// hold off long enough for the command queue to fill
				gap = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				gap = draw_gap(take_burst);
			end
			if (gap > 0) begin
				dig_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			dig_ready <= 1'b1;
			@(posedge clk);
			while (dig_valid !== 1'b1) @(posedge clk);
			words_taken++;
		end
	end

	initial begin
		int items_sent;
		int n_words;
		int cnt;
		arst_n <= 1'b0;
		msg_valid <= 1'b0;
		msg <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then full and partial final words
		send_item(rand_word(), 0, 1'b1);
		send_item('1, 8, 1'b1);
		send_item('0, 8, 1'b1);
		send_item('1, 1, 1'b1);
		send_item('1, 7, 1'b1);
		// counts above eight saturate
		send_item(rand_word(), 15, 1'b1);
		send_item(rand_word(), 9, 1'b1);
		// short words inside a message leave the state alone
		send_item('1, 8, 1'b0);
		send_item('0, 8, 1'b0);
		send_item(rand_word(), 0, 1'b0);
		send_item(rand_word(), 7, 1'b0);
		send_item(rand_word(), 12, 1'b0);
		send_item(rand_word(), 3, 1'b1);
		send_item(rand_word(), 15, 1'b0);
		send_item(rand_word(), 8, 1'b0);
		send_item('1, 5, 1'b1);
		send_item(rand_word(), 1, 1'b0);
		send_item(rand_word(), 0, 1'b1);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			n_words = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
			for (int i = 0; i < n_words; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(rand_word(), $urandom_range(0, 7), 1'b0);
					items_sent++;
				end
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : 8;
				send_item(rand_word(), cnt, 1'b0);
				items_sent++;
			end
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			send_item(rand_word(), cnt, 1'b1);
			items_sent++;
		end
		msg_valid <= 1'b0;

		do @(posedge clk); while (owed_words != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
